### rtl/alsid_pkg.sv
// shared types, codes and sizes for the shift insert/delete list
package alsid_pkg;

    localparam int CAPACITY   = 64;
    localparam int CELL_IDX_W = $clog2(CAPACITY);
    localparam int COUNT_W    = 7;
    localparam int DATA_W     = 32;
    localparam int GROUP      = 8;
    localparam int NGROUPS    = (CAPACITY + GROUP - 1) / GROUP;
    localparam int GRP_IDX_W  = $clog2(GROUP);
    localparam int GSEL_W     = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_LIST      = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_LIST
    } t_state;

    typedef enum logic [2:0] {
        CK_HOLD,
        CK_INSERT,
        CK_DELETE,
        CK_ROTATE,
        CK_SEARCH
    } t_cell_kind;

    typedef struct packed {
        logic [2:0]         operation;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         found_position;
        logic signed [31:0] element;
        logic               last;
        logic [6:0]         count;
    } t_out_word;

    // command broadcast to every cell of the chain
    typedef struct packed {
        t_cell_kind              kind;
        logic [CELL_IDX_W-1:0]   idx;
        logic [COUNT_W-1:0]      cnt;
        logic [DATA_W-1:0]       value;
    } t_cell_cmd;

endpackage

### rtl/alsid_cell.sv
// one storage cell of the list chain: holds an entry and a search match flag
module alsid_cell
    import alsid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  logic [CELL_IDX_W-1:0] i_index,
    input  logic [DATA_W-1:0]     i_left,
    input  logic [DATA_W-1:0]     i_right,
    input  logic [DATA_W-1:0]     i_head,
    output logic [DATA_W-1:0]     o_data,
    output logic                  o_match
);

    logic [DATA_W-1:0] r_data, n_data;
    logic              r_match, n_match;

    always_comb begin
        n_data = r_data;
        case (i_cmd.kind)
            CK_INSERT: begin
                if (i_index == i_cmd.idx) begin
                    n_data = i_cmd.value;
                end else if (i_index > i_cmd.idx) begin
                    n_data = i_left;
                end
            end
            CK_DELETE: begin
                if (i_index >= i_cmd.idx) begin
                    n_data = i_right;
                end
            end
            CK_ROTATE: begin
                // idx marks the tail cell, which takes the old head
                if (i_index == i_cmd.idx) begin
                    n_data = i_head;
                end else if (i_index < i_cmd.idx) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_comb begin
        n_match = r_match;
        if (i_cmd.kind == CK_SEARCH) begin
            n_match = (r_data == i_cmd.value) &&
                      ({1'b0, i_index} < i_cmd.cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

### rtl/alsid_find.sv
// first set match flag over the chain, found as groups of eight then group select
module alsid_find
    import alsid_pkg::*;
(
    input  logic [CAPACITY-1:0]   i_match,
    output logic                  o_found,
    output logic [CELL_IDX_W-1:0] o_index
);

    logic [NGROUPS-1:0]   grp_any;
    logic [GRP_IDX_W-1:0] grp_idx [NGROUPS];
    logic [GSEL_W-1:0]    sel;
    logic [CELL_IDX_W+GSEL_W+GRP_IDX_W-1:0] full_idx;

    // lowest set bit inside each group
    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            grp_any[g] = 1'b0;
            grp_idx[g] = '0;
            for (int b = GROUP - 1; b >= 0; b--) begin
                if (g * GROUP + b < CAPACITY) begin
                    if (i_match[g * GROUP + b]) begin
                        grp_any[g] = 1'b1;
                        grp_idx[g] = GRP_IDX_W'(b);
                    end
                end
            end
        end
    end

    // lowest group with a hit
    always_comb begin
        sel = '0;
        for (int g = NGROUPS - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                sel = GSEL_W'(g);
            end
        end
    end

    always_comb begin
        full_idx = (CELL_IDX_W + GSEL_W + GRP_IDX_W)'(sel)
                     * (CELL_IDX_W + GSEL_W + GRP_IDX_W)'(GROUP)
                 + (CELL_IDX_W + GSEL_W + GRP_IDX_W)'(grp_idx[sel]);
    end

    assign o_found = |grp_any;
    assign o_index = full_idx[CELL_IDX_W-1:0];

endmodule

### rtl/array_list_shift_insert_delete.sv
// top level of the ordered list: control sequencer over a chain of storage cells
//
// ordered list of up to 64 signed 32-bit entries kept in a chain of cells.
// a command word is taken at a rising edge where start is high and busy is
// low. each result word sits on o_result with o_strobe high for exactly one
// cycle, and the receiver cannot hold it off. on an insert or a delete the
// cells from the edit position on shift towards or away from a neighbour at
// the accepting edge (a tail delete shifts none), the result word follows in
// the cycle after acceptance, busy stays low and a new word may follow on
// the very next edge. a search raises busy: all cells latch their compare at
// the accepting edge, then a two-level first-match encoder picks the lowest
// position over those flags, and its result word is registered from there.
// a list on a non-empty chain keeps busy high while it runs: the chain
// rotates left once per cycle, the head cell feeding one result word each
// time, words go out back to back, and the order is back in place when the
// last word (flagged by last) goes out. a list on an empty chain answers
// like an edit, in the cycle after acceptance. the entry store is undefined
// after reset and has no clearing pass; only the count is cleared, and no
// entry at or beyond the count is ever read.
module array_list_shift_insert_delete
    import alsid_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_result
);

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_left, n_left;
    t_out_word          r_out, n_out;
    logic               r_strobe, n_strobe;

    t_cell_cmd             cell_cmd;
    logic [DATA_W-1:0]     cell_data [CAPACITY];
    logic [CAPACITY-1:0]   match_vec;
    logic                  find_hit;
    logic [CELL_IDX_W-1:0] find_idx;

    logic                  accept;
    t_op                   op;
    logic [COUNT_W-1:0]    pos_m1;
    logic [COUNT_W-1:0]    cnt_m1;
    logic                  ins_bad_pos;
    logic                  del_bad_pos;

    assign accept = start && (r_state == S_IDLE);
    assign op     = t_op'(i_cmd.operation);
    assign pos_m1 = i_cmd.position - COUNT_W'(1);
    assign cnt_m1 = r_count - COUNT_W'(1);

    // insert-at may land just past the tail, delete-at only on a stored entry
    assign ins_bad_pos = (i_cmd.position == '0) ||
                         ({1'b0, i_cmd.position} > ({1'b0, r_count} + 8'd1));
    assign del_bad_pos = (i_cmd.position == '0) || (i_cmd.position > r_count);

    // chain of cells, each handing its entry to a neighbour when told
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_data, right_data;

        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_l
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid_r
            assign right_data = cell_data[g+1];
        end

        alsid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cell_cmd),
            .i_index (CELL_IDX_W'(g)),
            .i_left  (left_data),
            .i_right (right_data),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[g]),
            .o_match (match_vec[g])
        );
    end

    // first match over the registered compare flags
    alsid_find u_find (
        .i_match (match_vec),
        .o_found (find_hit),
        .o_index (find_idx)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (op == OP_SEARCH) begin
                        n_state = S_FIND;
                    end else if ((op == OP_LIST) && (r_count != '0)) begin
                        n_state = S_LIST;
                    end
                end
            end
            S_FIND: n_state = S_IDLE;
            S_LIST: begin
                if (r_left == COUNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell commands, count update and result word
    always_comb begin
        cell_cmd.kind  = CK_HOLD;
        cell_cmd.idx   = '0;
        cell_cmd.cnt   = r_count;
        cell_cmd.value = i_cmd.value;
        n_count        = r_count;
        n_left         = r_left;
        n_strobe       = 1'b0;
        n_out.status         = ST_OK;
        n_out.found_position = '0;
        n_out.element        = '0;
        n_out.last           = 1'b1;
        n_out.count          = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    unique case (op)
                        OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                            if (r_count >= COUNT_W'(CAPACITY)) begin
                                n_out.status = ST_FULL;
                            end else if ((op == OP_INS_AT) && ins_bad_pos) begin
                                n_out.status = ST_BADPOS;
                            end else begin
                                cell_cmd.kind = CK_INSERT;
                                if (op == OP_INS_END) begin
                                    cell_cmd.idx = r_count[CELL_IDX_W-1:0];
                                end else if (op == OP_INS_AT) begin
                                    cell_cmd.idx = pos_m1[CELL_IDX_W-1:0];
                                end
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else if ((op == OP_DEL_AT) && del_bad_pos) begin
                                n_out.status = ST_BADPOS;
                            end else begin
                                // dropping the tail needs no shift at all
                                if (op == OP_DEL_FRONT) begin
                                    cell_cmd.kind = CK_DELETE;
                                end else if (op == OP_DEL_AT) begin
                                    cell_cmd.kind = CK_DELETE;
                                    cell_cmd.idx  = pos_m1[CELL_IDX_W-1:0];
                                end
                                n_count = cnt_m1;
                            end
                        end
                        OP_SEARCH: begin
                            // cells latch their compare, result word follows
                            cell_cmd.kind = CK_SEARCH;
                            n_strobe      = 1'b0;
                        end
                        OP_LIST: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_strobe = 1'b0;
                                n_left   = r_count;
                            end
                        end
                        default: n_strobe = 1'b0;
                    endcase
                end
            end
            S_FIND: begin
                n_strobe = 1'b1;
                if (find_hit) begin
                    n_out.found_position = COUNT_W'(find_idx) + COUNT_W'(1);
                end else begin
                    n_out.status = ST_NOTFOUND;
                end
            end
            S_LIST: begin
                // head goes out while the chain rotates it to the tail
                n_strobe      = 1'b1;
                cell_cmd.kind = CK_ROTATE;
                cell_cmd.idx  = cnt_m1[CELL_IDX_W-1:0];
                n_out.element = cell_data[0];
                n_out.last    = (r_left == COUNT_W'(1));
                n_left        = r_left - COUNT_W'(1);
            end
            default: n_strobe = 1'b0;
        endcase

        n_out.count = n_count;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    // result word register, no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // count never runs past the chain length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("list count beyond capacity");

    // a result word only follows an accepted word or a busy cycle
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ($past(accept) || $past(busy)))
        else $error("result word with no cause");

    // a list word that is not the last keeps the block busy
    a_list_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_out.last) |-> busy)
        else $error("list ended before its last word");

    // count moves only on an accepted edit
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("count changed with no accepted word");

endmodule

### tb/sv/array_list_shift_insert_delete_tb.sv
// testbench for the shift insert/delete ordered list: directed and random command words
`timescale 1ns / 100ps

module array_list_shift_insert_delete_tb
    import alsid_pkg::*;
();

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_word  cmd;
    logic      busy;
    logic      o_strobe;
    t_out_word o_result;

    // shadow of the list contents, head entry at index 0
    logic signed [31:0] list_shadow[$];
    // result words still owed by the block, in order
    t_out_word          owed_words[$];
    t_out_word          head_word;
    int                 err_count;
    // random gaps before a command word are switched on and off per phase
    bit                 gaps_on;

    array_list_shift_insert_delete DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 12 ns period
    always #6 i_clk = ~i_clk;

    // queue one owed result word, count taken from the shadow after the edit
    function automatic void owe_word(t_status st, logic [6:0] fpos,
                                     logic signed [31:0] elem, logic lst);
        t_out_word w;
        w.status         = st;
        w.found_position = fpos;
        w.element        = elem;
        w.last           = lst;
        w.count          = 7'(list_shadow.size());
        owed_words.push_back(w);
    endfunction

    // apply one accepted command word to the shadow list and queue its results
    function automatic void apply_list_op(t_in_word w);
        t_op op;
        int  n;
        int  pos;
        int  hit;
        op  = t_op'(w.operation);
        n   = list_shadow.size();
        pos = w.position;
        hit = 0;
        case (op)
            OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                // fullness wins over a bad position
                if (n >= CAPACITY) begin
                    owe_word(ST_FULL, 7'd0, 32'sd0, 1'b1);
                end else if (op == OP_INS_FRONT) begin
                    list_shadow.push_front(w.value);
                    owe_word(ST_OK, 7'd0, 32'sd0, 1'b1);
                end else if (op == OP_INS_END) begin
                    list_shadow.push_back(w.value);
                    owe_word(ST_OK, 7'd0, 32'sd0, 1'b1);
                end else if (pos < 1 || pos > n + 1) begin
                    owe_word(ST_BADPOS, 7'd0, 32'sd0, 1'b1);
                end else begin
                    list_shadow.insert(pos - 1, w.value);
                    owe_word(ST_OK, 7'd0, 32'sd0, 1'b1);
                end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
                // emptiness wins over a bad position
                if (n == 0) begin
                    owe_word(ST_EMPTY, 7'd0, 32'sd0, 1'b1);
                end else if (op == OP_DEL_FRONT) begin
                    void'(list_shadow.pop_front());
                    owe_word(ST_OK, 7'd0, 32'sd0, 1'b1);
                end else if (op == OP_DEL_END) begin
                    void'(list_shadow.pop_back());
                    owe_word(ST_OK, 7'd0, 32'sd0, 1'b1);
                end else if (pos < 1 || pos > n) begin
                    owe_word(ST_BADPOS, 7'd0, 32'sd0, 1'b1);
                end else begin
                    list_shadow.delete(pos - 1);
                    owe_word(ST_OK, 7'd0, 32'sd0, 1'b1);
                end
            end
            OP_SEARCH: begin
                // first match only
                for (int i = 0; i < n; i++) begin
                    if (list_shadow[i] == w.value) begin
                        hit = i + 1;
                        break;
                    end
                end
                owe_word(hit != 0 ? ST_OK : ST_NOTFOUND, 7'(hit), 32'sd0, 1'b1);
            end
            default: begin
                // list: one word per entry, or a single empty word
                if (n == 0) begin
                    owe_word(ST_EMPTY, 7'd0, 32'sd0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        owe_word(ST_OK, 7'd0, list_shadow[i], i == n - 1);
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic signed [32:0] want,
                                        logic signed [32:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // values biased towards the extremes and towards a narrow band for duplicates
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return $signed(32'($urandom_range(8))) - 32'sd4;
            default: return $signed(32'($urandom));
        endcase
    endfunction

    // drive one command word and hold it until accepted; the shadow is updated
    // at the accepting edge, so it is current when this task returns
    task automatic send_word(t_op op, logic [6:0] pos, logic signed [31:0] val);
        t_in_word w;
        int       gap;
        w.operation = op;
        w.position  = pos;
        w.value     = val;
        gap = 0;
        // each cycle idles with the same chance, so idle cycles come out near 29 in 100
        while (gaps_on && $urandom_range(99) < 29)
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        cmd   <= w;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        apply_list_op(w);
    endtask

    // stop sending and wait until every owed word has come back
    task automatic wait_all_words();
        @(negedge i_clk);
        start <= 1'b0;
        while (owed_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result checker: a word is taken at the edge that ends its strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (owed_words.size() == 0) begin
                    $error("result word with nothing owed");
                    err_count++;
                end else begin
                    head_word = owed_words.pop_front();
                    check_field("status", head_word.status, o_result.status);
                    check_field("found_position", head_word.found_position,
                                o_result.found_position);
                    check_field("element", head_word.element, o_result.element);
                    check_field("last", head_word.last, o_result.last);
                    check_field("count", head_word.count, o_result.count);
                end
            end else if (o_strobe !== 1'b0) begin
                $error("o_strobe unknown");
                err_count++;
            end
        end
    end

    // every error path on an empty list
    task automatic test_empty_list();
        send_word(OP_DEL_FRONT, 7'd0, 32'sd0);
        send_word(OP_DEL_END, 7'd127, 32'sd0);
        send_word(OP_DEL_AT, 7'd1, 32'sd0);
        send_word(OP_SEARCH, 7'd0, 32'sd0);
        send_word(OP_LIST, 7'd0, 32'sd0);
        send_word(OP_INS_AT, 7'd0, 32'sd1);
        send_word(OP_INS_AT, 7'd2, 32'sd1);
        send_word(OP_INS_AT, 7'd127, 32'sd1);
    endtask

    // edits at both ends and in the middle, bad positions, search hit, miss and duplicate
    task automatic test_edits_and_search();
        send_word(OP_INS_AT, 7'd1, 32'sh7fff_ffff);
        send_word(OP_INS_FRONT, 7'd0, 32'sh8000_0000);
        send_word(OP_INS_END, 7'd0, 32'sd0);
        send_word(OP_INS_END, 7'd0, -32'sd1);
        send_word(OP_INS_AT, 7'd5, 32'sh5555_5555);
        send_word(OP_INS_AT, 7'd3, 32'shaaaa_aaaa);
        send_word(OP_INS_AT, 7'd8, 32'sd7);
        send_word(OP_DEL_AT, 7'd0, 32'sd0);
        send_word(OP_DEL_AT, 7'd7, 32'sd0);
        send_word(OP_DEL_AT, 7'd127, 32'sd0);
        send_word(OP_SEARCH, 7'd0, 32'sh5555_5555);
        send_word(OP_SEARCH, 7'd0, 32'sh1234_5678);
        send_word(OP_INS_FRONT, 7'd0, -32'sd1);
        send_word(OP_SEARCH, 7'd0, -32'sd1);
        send_word(OP_LIST, 7'd0, 32'sd0);
        send_word(OP_DEL_AT, 7'd2, 32'sd0);
        send_word(OP_DEL_FRONT, 7'd0, 32'sd0);
        send_word(OP_DEL_END, 7'd0, 32'sd0);
        send_word(OP_LIST, 7'd0, 32'sd0);
    endtask

    // fill to capacity, hit every full case, list all entries, then empty it out
    task automatic test_full_list();
        int n;
        while (list_shadow.size() < CAPACITY)
            send_word(OP_INS_END, 7'($urandom_range(127)), rand_value());
        send_word(OP_INS_FRONT, 7'd0, 32'sd1);
        send_word(OP_INS_END, 7'd0, 32'sd1);
        send_word(OP_INS_AT, 7'd65, 32'sd1);
        send_word(OP_INS_AT, 7'd127, 32'sd1);
        send_word(OP_INS_AT, 7'd0, 32'sd1);
        send_word(OP_SEARCH, 7'd0, list_shadow[CAPACITY - 1]);
        send_word(OP_LIST, 7'd0, 32'sd0);
        send_word(OP_DEL_AT, 7'd64, 32'sd0);
        send_word(OP_INS_AT, 7'd64, 32'sh7fff_ffff);
        send_word(OP_DEL_AT, 7'd65, 32'sd0);
        while (list_shadow.size() > 0) begin
            n = list_shadow.size();
            case ($urandom_range(2))
                0:       send_word(OP_DEL_FRONT, 7'($urandom_range(127)), 32'sd0);
                1:       send_word(OP_DEL_END, 7'($urandom_range(127)), 32'sd0);
                default: send_word(OP_DEL_AT, 7'($urandom_range(1, n)), 32'sd0);
            endcase
        end
        send_word(OP_DEL_END, 7'd0, 32'sd0);
        send_word(OP_LIST, 7'd0, 32'sd0);
    endtask

    // random walk over the list: mostly well-formed edits, some bad positions
    task automatic test_random_ops(int num_words);
        int n;
        int r;
        int p_ins;
        for (int k = 0; k < num_words; k++) begin
            // long stretch with no gaps first, then gaps, and one full drain midway
            gaps_on = (k >= num_words / 3);
            if (k == 2 * num_words / 3)
                wait_all_words();
            n     = list_shadow.size();
            p_ins = (n < 8) ? 60 : (n > 56) ? 25 : 40;
            r     = $urandom_range(99);
            if (r < p_ins) begin
                case ($urandom_range(2))
                    0:       send_word(OP_INS_FRONT, 7'($urandom_range(127)), rand_value());
                    1:       send_word(OP_INS_END, 7'($urandom_range(127)), rand_value());
                    default: begin
                        if ($urandom_range(99) < 15)
                            send_word(OP_INS_AT, 7'($urandom_range(127)), rand_value());
                        else
                            send_word(OP_INS_AT, 7'($urandom_range(1, n + 1)), rand_value());
                    end
                endcase
            end else if (r < p_ins + 35) begin
                case ($urandom_range(2))
                    0:       send_word(OP_DEL_FRONT, 7'($urandom_range(127)), rand_value());
                    1:       send_word(OP_DEL_END, 7'($urandom_range(127)), rand_value());
                    default: begin
                        if (n == 0 || $urandom_range(99) < 15)
                            send_word(OP_DEL_AT, 7'($urandom_range(127)), rand_value());
                        else
                            send_word(OP_DEL_AT, 7'($urandom_range(1, n)), rand_value());
                    end
                endcase
            end else if (r < p_ins + 50) begin
                // search keys mostly taken from the list itself
                if (n > 0 && $urandom_range(99) < 60)
                    send_word(OP_SEARCH, 7'($urandom_range(127)),
                              list_shadow[$urandom_range(n - 1)]);
                else
                    send_word(OP_SEARCH, 7'($urandom_range(127)), rand_value());
            end else begin
                send_word(OP_LIST, 7'($urandom_range(127)), rand_value());
            end
        end
    endtask

    initial begin
        i_clk     = 1'b0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        err_count = 0;
        gaps_on   = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edits_and_search();
        test_full_list();
        test_random_ops(140);
        wait_all_words();

        if (err_count == 0) begin
            $display("array_list_shift_insert_delete_tb passed");
        end else begin
            $display("array_list_shift_insert_delete_tb failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("array_list_shift_insert_delete_tb failed");
        $finish;
    end

endmodule

### array_list_shift_insert_delete.f
rtl/alsid_pkg.sv
rtl/alsid_cell.sv
rtl/alsid_find.sv
rtl/array_list_shift_insert_delete.sv
tb/sv/array_list_shift_insert_delete_tb.sv
